[src/ssrr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the RRIP replacement block.
package ssrr_pkg;

	localparam int DEF_NUM_SETS    = 2048;
	localparam int DEF_NUM_WAYS    = 16;
	localparam int DEF_SIG_ENTRIES = 8;
	localparam int DEF_HISTORY_LEN = 4;

	localparam int PC_W      = 48;
	localparam int ADDR_W    = 48;
	localparam int STRIDE_W  = 49;
	localparam int STAMP_W   = 32;
	localparam int REUSE_W   = 3;
	localparam int RRPV_W    = 2;
	localparam int TOL_W     = 12;
	localparam int SET_IN_W  = 11;
	localparam int WAY_IN_W  = 4;
	localparam int VICTIM_W  = 4;

	localparam logic [TOL_W-1:0]   TOL_RESET   = 12'd64;
	localparam logic [REUSE_W-1:0] REUSE_MAX   = 3'd7;
	localparam logic [REUSE_W-1:0] REUSE_INIT  = 3'd1;
	localparam logic [REUSE_W-1:0] REUSE_HOT   = 3'd6;
	localparam logic [REUSE_W-1:0] REUSE_WARM  = 3'd3;
	localparam logic [RRPV_W-1:0]  RRPV_MAX    = 2'd3;
	localparam logic [RRPV_W-1:0]  RRPV_INSERT = 2'd2;
	localparam logic [RRPV_W-1:0]  RRPV_NEAR   = 2'd1;
	localparam logic [RRPV_W-1:0]  RRPV_HIT    = 2'd0;

	localparam logic ACT_VICTIM = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic clr;
		logic load_in;
		logic mod_step;
		logic set_rd;
		logic set_ld;
		logic hist_upd;
		logic cons_ld;
		logic way_init;
		logic way_next;
		logic line_rd;
		logic find_init;
		logic sig_rd;
		logic sig_cmp;
		logic pick;
		logic train;
		logic line_wr;
		logic set_wr;
		logic out_load;
	} ssrr_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic mod_done;
		logic is_update;
		logic rrpv_eq;
		logic way_last;
		logic sig_hit;
		logic ent_last;
		logic out_free;
	} ssrr_sts_t;

endpackage

[src/ssrr_ram.sv]
// Generic simple dual-port RAM with registered read.
module ssrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/ssrr_ctrl.sv]
// Sequencing state machine for victim search, update and the reset clearing pass.
module ssrr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output ssrr_pkg::ssrr_cmd_t cmd,
	input  ssrr_pkg::ssrr_sts_t sts
);
	import ssrr_pkg::*;

	typedef enum logic [15:0] {
		S_CLEAR = 16'b0000_0000_0000_0001,
		S_IDLE  = 16'b0000_0000_0000_0010,
		S_MOD   = 16'b0000_0000_0000_0100,
		S_SRD   = 16'b0000_0000_0000_1000,
		S_SLD   = 16'b0000_0000_0001_0000,
		S_HIST  = 16'b0000_0000_0010_0000,
		S_CONS  = 16'b0000_0000_0100_0000,
		S_VCHK  = 16'b0000_0000_1000_0000,
		S_VLLD  = 16'b0000_0001_0000_0000,
		S_FRD   = 16'b0000_0010_0000_0000,
		S_FCMP  = 16'b0000_0100_0000_0000,
		S_PICK  = 16'b0000_1000_0000_0000,
		S_TRAIN = 16'b0001_0000_0000_0000,
		S_LWR   = 16'b0010_0000_0000_0000,
		S_SWR   = 16'b0100_0000_0000_0000,
		S_OUT   = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) state_d = S_SRD;
			end
			S_SRD: begin
				cmd.set_rd = 1'b1;
				state_d    = S_SLD;
			end
			S_SLD: begin
				cmd.set_ld = 1'b1;
				state_d    = sts.is_update ? S_HIST : S_CONS;
			end
			S_HIST: begin
				cmd.hist_upd = 1'b1;
				state_d      = S_CONS;
			end
			S_CONS: begin
				cmd.cons_ld = 1'b1;
				if (sts.is_update) begin
					cmd.find_init = 1'b1;
					state_d       = S_FRD;
				end else begin
					cmd.way_init = 1'b1;
					state_d      = S_VCHK;
				end
			end
			S_VCHK: begin
				if (sts.rrpv_eq) begin
					cmd.line_rd = 1'b1;
					state_d     = S_VLLD;
				end else if (sts.way_last) begin
					state_d = S_SWR;
				end else begin
					cmd.way_next = 1'b1;
				end
			end
			S_VLLD: begin
				cmd.find_init = 1'b1;
				state_d       = S_FRD;
			end
			S_FRD: begin
				cmd.sig_rd = 1'b1;
				state_d    = S_FCMP;
			end
			S_FCMP: begin
				cmd.sig_cmp = 1'b1;
				if (sts.sig_hit || sts.ent_last) begin
					state_d = sts.is_update ? S_TRAIN : S_PICK;
				end else begin
					state_d = S_FRD;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				if (sts.way_last) begin
					state_d = S_SWR;
				end else begin
					cmd.way_next = 1'b1;
					state_d      = S_VCHK;
				end
			end
			S_TRAIN: begin
				cmd.train = 1'b1;
				state_d   = S_LWR;
			end
			S_LWR: begin
				cmd.line_wr = 1'b1;
				state_d     = S_SWR;
			end
			S_SWR: begin
				cmd.set_wr = 1'b1;
				state_d    = sts.is_update ? S_IDLE : S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MOD))
		else $error("accepted transaction did not start set reduction");

	a_result_victim_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.is_update)
		else $error("result produced for an update transaction");

	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !sts.clr_done) |=> (state_q == S_CLEAR))
		else $error("clearing pass left early");

	a_writeback_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_wr |=> (state_q == S_IDLE || state_q == S_OUT))
		else $error("set write-back not followed by completion");
endmodule

[src/ssrr_dp.sv]
// Datapath: set, line and signature memories, history registers and victim search logic.
module ssrr_dp #(
	parameter int NUM_SETS    = ssrr_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS    = ssrr_pkg::DEF_NUM_WAYS,
	parameter int SIG_ENTRIES = ssrr_pkg::DEF_SIG_ENTRIES,
	parameter int HISTORY_LEN = ssrr_pkg::DEF_HISTORY_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssrr_pkg::ssrr_cmd_t           cmd,
	output ssrr_pkg::ssrr_sts_t           sts,
	input  logic                          cfg_we,
	input  logic [ssrr_pkg::TOL_W-1:0]    cfg_wdata,
	input  logic                          action,
	input  logic [ssrr_pkg::SET_IN_W-1:0] set_index,
	input  logic [ssrr_pkg::WAY_IN_W-1:0] way_index,
	input  logic [ssrr_pkg::PC_W-1:0]     access_pc,
	input  logic [ssrr_pkg::ADDR_W-1:0]   access_addr,
	input  logic                          was_hit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ssrr_pkg::VICTIM_W-1:0] victim_way
);
	import ssrr_pkg::*;

	localparam int SA_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WW      = $clog2(NUM_WAYS);
	localparam int EW      = $clog2(SIG_ENTRIES);
	localparam int PW      = $clog2(HISTORY_LEN);
	localparam int CW      = $clog2(HISTORY_LEN + 1);
	localparam int XW      = (WW > EW) ? WW : EW;
	localparam int CLR_W   = SA_W + XW;
	localparam int LINE_AW = SA_W + WW;
	localparam int SIG_AW  = SA_W + EW;
	localparam int LINE_DW = PC_W + ADDR_W;
	localparam int SIG_DW  = PC_W + REUSE_W + STAMP_W;
	localparam int ROW_W   = STAMP_W + HISTORY_LEN * ADDR_W + (HISTORY_LEN - 1) * STRIDE_W
		+ PW + CW + NUM_WAYS * RRPV_W;
	localparam int SK_W    = 2;
	localparam int MINR_W  = REUSE_W + 1;
	localparam int DIF_W   = STRIDE_W + 1;

	// reciprocal of NUM_SETS; quotient estimate is low by at most one for 11-bit indexes
	localparam int          RECIP_SH = 2 * SET_IN_W;
	localparam int          PROD_W   = SET_IN_W + RECIP_SH + 1;
	localparam longint      RECIP_L  = (longint'(1) << RECIP_SH) / NUM_SETS;
	localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'(RECIP_L);

	localparam logic [SIG_DW-1:0] SIG_RESET = {{PC_W{1'b0}}, REUSE_INIT, {STAMP_W{1'b0}}};
	localparam logic [ROW_W-1:0]  ROW_RESET = {{(ROW_W - NUM_WAYS * RRPV_W){1'b0}},
		{NUM_WAYS{RRPV_MAX}}};

	function automatic logic [DIF_W-1:0] dabs(input logic [DIF_W-1:0] v);
		return v[DIF_W-1] ? (~v + 1'b1) : v;
	endfunction

	// control registers
	logic [TOL_W-1:0] tol_q;
	logic [CLR_W-1:0] clr_q;
	logic             out_valid_q;

	// request
	logic                act_q;
	logic [SET_IN_W-1:0] set_q;
	logic [WAY_IN_W-1:0] way_in_q;
	logic [PC_W-1:0]     pc_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                hit_q;
	logic [SK_W-1:0]     k_q;
	logic [SET_IN_W-1:0] quo_q;

	// per-set row
	logic [STAMP_W-1:0]                        tick_q;
	logic [HISTORY_LEN-1:0][ADDR_W-1:0]        hist_q;
	logic [HISTORY_LEN-2:0][STRIDE_W-1:0]      strd_q;
	logic [PW-1:0]                             ptr_q;
	logic [CW-1:0]                             cnt_q;
	logic [NUM_WAYS-1:0][RRPV_W-1:0]           rrpv_q;

	// search
	logic                cons_q;
	logic [RRPV_W-1:0]   maxr_q;
	logic [WW-1:0]       way_q;
	logic [MINR_W-1:0]   minr_q;
	logic [WW-1:0]       victim_q;
	logic [PC_W-1:0]     key_q;
	logic                match_q;
	logic [EW-1:0]       e_q;
	logic [STAMP_W-1:0]  min_stamp_q;
	logic [EW-1:0]       min_idx_q;
	logic [REUSE_W-1:0]  reuse_q;
	logic [EW-1:0]       idx_q;
	logic [VICTIM_W-1:0] out_way_q;

	// memories
	logic [ROW_W-1:0]   set_rdata, set_wdata;
	logic [SA_W-1:0]    set_waddr;
	logic [LINE_DW-1:0] line_rdata, line_wdata;
	logic [LINE_AW-1:0] line_waddr;
	logic               line_we;
	logic [SIG_DW-1:0]  sig_rdata, sig_wdata;
	logic [SIG_AW-1:0]  sig_waddr;
	logic               sig_we;

	logic [SA_W-1:0]     set_a;
	logic [PROD_W-1:0]   prod_c;
	logic [31:0]         back_c;
	logic [PW-1:0]       newest_idx;
	logic [ADDR_W-1:0]   newest;
	logic [STRIDE_W-1:0] st_c, st_line;
	logic [DIF_W-1:0]    d_line;
	logic                cons_c;
	logic [RRPV_W-1:0]   maxr_c;
	logic                f1, f2, f3;
	logic [PC_W-1:0]     s_pc;
	logic [REUSE_W-1:0]  s_reuse;
	logic [STAMP_W-1:0]  s_stamp;
	logic                s_hit;
	logic                ent_last;
	logic [EW-1:0]       best_idx;
	logic [STAMP_W-1:0]  best_stamp;
	logic                sig_ins;
	logic [REUSE_W-1:0]  trained;
	logic [RRPV_W-1:0]   rrpv_new;
	logic                way_ok;
	logic [STAMP_W-1:0]  tick_inc;

	assign set_a    = SA_W'(set_q);
	assign prod_c   = PROD_W'(set_q) * PROD_W'(RECIP);
	assign back_c   = 32'(quo_q) * 32'(NUM_SETS);
	assign tick_inc = tick_q + STAMP_W'(1);
	assign way_ok   = (int'(way_in_q) < NUM_WAYS);

	assign newest_idx = (ptr_q == '0) ? PW'(HISTORY_LEN - 1) : ptr_q - 1'b1;
	always_comb begin
		newest = '0;
		for (int i = 0; i < HISTORY_LEN; i++) begin
			if (newest_idx == PW'(i)) newest = hist_q[i];
		end
	end

	assign st_c    = {1'b0, addr_q} - {1'b0, newest};
	assign st_line = {1'b0, line_rdata[ADDR_W-1:0]} - {1'b0, newest};
	assign d_line  = {st_line[STRIDE_W-1], st_line} - {strd_q[0][STRIDE_W-1], strd_q[0]};

	// consistent stride over the full history
	always_comb begin
		logic [DIF_W-1:0] d;
		cons_c = (cnt_q == CW'(HISTORY_LEN));
		for (int i = 1; i < HISTORY_LEN - 1; i++) begin
			d = {strd_q[i][STRIDE_W-1], strd_q[i]} - {strd_q[0][STRIDE_W-1], strd_q[0]};
			if (dabs(d) > DIF_W'(tol_q)) cons_c = 1'b0;
		end
	end

	always_comb begin
		f1 = 1'b0;
		f2 = 1'b0;
		f3 = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			f3 = f3 | (rrpv_q[w] == RRPV_MAX);
			f2 = f2 | (rrpv_q[w] == RRPV_INSERT);
			f1 = f1 | (rrpv_q[w] == RRPV_NEAR);
		end
		maxr_c = f3 ? RRPV_MAX : f2 ? RRPV_INSERT : f1 ? RRPV_NEAR : RRPV_HIT;
	end

	assign {s_pc, s_reuse, s_stamp} = sig_rdata;
	assign s_hit      = (s_pc == key_q);
	assign ent_last   = (e_q == EW'(SIG_ENTRIES - 1));
	assign best_idx   = (e_q == '0 || s_stamp < min_stamp_q) ? e_q : min_idx_q;
	assign best_stamp = (e_q == '0 || s_stamp < min_stamp_q) ? s_stamp : min_stamp_q;
	assign sig_ins    = cmd.sig_cmp && !s_hit && ent_last;

	always_comb begin
		if (hit_q) begin
			trained = (reuse_q < REUSE_MAX) ? reuse_q + 1'b1 : REUSE_MAX;
		end else begin
			trained = (reuse_q > REUSE_INIT) ? reuse_q - 1'b1 : REUSE_INIT;
		end
	end

	assign rrpv_new = (hit_q || reuse_q >= REUSE_HOT || cons_q) ? RRPV_HIT :
		(reuse_q >= REUSE_WARM) ? RRPV_NEAR : RRPV_INSERT;

	// memory ports
	assign set_wdata  = cmd.clr ? ROW_RESET : {tick_q, hist_q, strd_q, ptr_q, cnt_q, rrpv_q};
	assign set_waddr  = cmd.clr ? clr_q[SA_W-1:0] : set_a;
	assign line_we    = cmd.clr || (cmd.line_wr && way_ok);
	assign line_waddr = cmd.clr ? clr_q[LINE_AW-1:0] : {set_a, WW'(way_in_q)};
	assign line_wdata = cmd.clr ? '0 : {pc_q, addr_q};
	assign sig_we     = cmd.clr || sig_ins || cmd.train;
	assign sig_waddr  = cmd.clr ? clr_q[SIG_AW-1:0] : {set_a, (cmd.train ? idx_q : best_idx)};
	assign sig_wdata  = cmd.clr ? SIG_RESET :
		{key_q, (cmd.train ? trained : REUSE_INIT), tick_inc};

	ssrr_ram #(.WIDTH(ROW_W), .DEPTH(2 ** SA_W)) u_set_ram (
		.clk  (clk),
		.we   (cmd.clr || cmd.set_wr),
		.waddr(set_waddr),
		.wdata(set_wdata),
		.re   (cmd.set_rd),
		.raddr(set_a),
		.rdata(set_rdata)
	);

	ssrr_ram #(.WIDTH(LINE_DW), .DEPTH(2 ** LINE_AW)) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_waddr),
		.wdata(line_wdata),
		.re   (cmd.line_rd),
		.raddr({set_a, way_q}),
		.rdata(line_rdata)
	);

	ssrr_ram #(.WIDTH(SIG_DW), .DEPTH(2 ** SIG_AW)) u_sig_ram (
		.clk  (clk),
		.we   (sig_we),
		.waddr(sig_waddr),
		.wdata(sig_wdata),
		.re   (cmd.sig_rd),
		.raddr({set_a, e_q}),
		.rdata(sig_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) tol_q <= cfg_wdata;
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q    <= action;
			set_q    <= set_index;
			way_in_q <= way_index;
			pc_q     <= access_pc;
			addr_q   <= access_addr;
			hit_q    <= was_hit;
			k_q      <= SK_W'(2);
		end
		// set index modulo NUM_SETS: quotient estimate, remainder, one correction
		if (cmd.mod_step) begin
			if (k_q == SK_W'(2)) begin
				quo_q <= prod_c[RECIP_SH +: SET_IN_W];
			end else if (k_q == SK_W'(1)) begin
				set_q <= set_q - SET_IN_W'(back_c);
			end else if (32'(set_q) >= 32'(NUM_SETS)) begin
				set_q <= set_q - SET_IN_W'(NUM_SETS);
			end
			k_q <= k_q - 1'b1;
		end
		if (cmd.set_ld) begin
			{tick_q, hist_q, strd_q, ptr_q, cnt_q, rrpv_q} <= set_rdata;
		end
		if (cmd.hist_upd) begin
			for (int i = 0; i < HISTORY_LEN - 1; i++) begin
				if (ptr_q == PW'(i + 1)) strd_q[i] <= st_c;
			end
			for (int i = 0; i < HISTORY_LEN; i++) begin
				if (ptr_q == PW'(i)) hist_q[i] <= addr_q;
			end
			ptr_q <= (ptr_q == PW'(HISTORY_LEN - 1)) ? '0 : ptr_q + 1'b1;
			if (cnt_q < CW'(HISTORY_LEN)) cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.cons_ld) begin
			cons_q <= cons_c;
			maxr_q <= maxr_c;
		end
		if (cmd.way_init) begin
			way_q    <= '0;
			minr_q   <= MINR_W'(REUSE_MAX) + 1'b1;
			victim_q <= '0;
		end
		if (cmd.way_next) way_q <= way_q + 1'b1;
		if (cmd.find_init) begin
			key_q   <= (act_q == ACT_UPDATE) ? pc_q : line_rdata[LINE_DW-1 -: PC_W];
			match_q <= cons_q && (dabs(d_line) <= DIF_W'(tol_q));
			e_q     <= '0;
		end
		if (cmd.sig_cmp) begin
			if (s_hit) begin
				reuse_q <= s_reuse;
				idx_q   <= e_q;
			end else begin
				min_stamp_q <= best_stamp;
				min_idx_q   <= best_idx;
				if (ent_last) begin
					tick_q  <= tick_inc;
					reuse_q <= REUSE_INIT;
					idx_q   <= best_idx;
				end else begin
					e_q <= e_q + 1'b1;
				end
			end
		end
		if (cmd.pick) begin
			if (MINR_W'(reuse_q) < minr_q || (MINR_W'(reuse_q) == minr_q && !match_q)) begin
				minr_q   <= MINR_W'(reuse_q);
				victim_q <= way_q;
			end
		end
		if (cmd.train) begin
			tick_q  <= tick_inc;
			reuse_q <= trained;
		end
		if (cmd.line_wr && way_ok) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (WW'(way_in_q) == WW'(w)) rrpv_q[w] <= rrpv_new;
			end
		end
		if (cmd.out_load) out_way_q <= VICTIM_W'(victim_q);
	end

	always_comb begin
		sts.clr_done  = &clr_q;
		sts.mod_done  = (k_q == '0);
		sts.is_update = (act_q == ACT_UPDATE);
		sts.rrpv_eq   = (rrpv_q[way_q] == maxr_q);
		sts.way_last  = (way_q == WW'(NUM_WAYS - 1));
		sts.sig_hit   = s_hit;
		sts.ent_last  = ent_last;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign victim_way = out_way_q;
endmodule

[src/signature_stride_rrip_replacement.sv]
// Top level of the signature and stride aware RRIP replacement policy.
//
// Input channel (in_valid/in_ready) carries one request transaction: action 0 asks for a
// victim way in set_index, action 1 reports an access (way, PC, address, hit) for training.
// Output channel (out_valid/out_ready) returns victim_way, one transaction per victim request;
// updates return nothing.
// Requests are handled one at a time, in_ready low until the current one completes. Both
// kinds first reduce set_index modulo NUM_SETS by a reciprocal multiply and one correction.
//   update: set read, history update, signature scan (a RAM read and compare per entry, up
//           to SIG_ENTRIES entries), training, line and set write-back;
//   victim: set read, each way in turn (line read and signature scan for a way at the top
//           re-reference value), set write-back, then a wait for a free output register.
// A finished victim waits in an output register; a new request is accepted while it waits,
// but the next victim cannot be loaded until the receiver takes the previous one.
// After reset the block sweeps all memories to their reset contents, one entry per cycle;
// in_ready stays low meanwhile. stride_tolerance writes (cfg_we) are taken anytime.
module signature_stride_rrip_replacement #(
	parameter int NUM_SETS    = ssrr_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS    = ssrr_pkg::DEF_NUM_WAYS,
	parameter int SIG_ENTRIES = ssrr_pkg::DEF_SIG_ENTRIES,
	parameter int HISTORY_LEN = ssrr_pkg::DEF_HISTORY_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ssrr_pkg::TOL_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [ssrr_pkg::SET_IN_W-1:0] set_index,
	input  logic [ssrr_pkg::WAY_IN_W-1:0] way_index,
	input  logic [ssrr_pkg::PC_W-1:0]     access_pc,
	input  logic [ssrr_pkg::ADDR_W-1:0]   access_addr,
	input  logic                          was_hit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ssrr_pkg::VICTIM_W-1:0] victim_way
);
	import ssrr_pkg::*;

	ssrr_cmd_t cmd;
	ssrr_sts_t sts;

	// sequencer: owns the handshake on the request side
	ssrr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// memories, history and search arithmetic; owns the result register
	ssrr_dp #(
		.NUM_SETS   (NUM_SETS),
		.NUM_WAYS   (NUM_WAYS),
		.SIG_ENTRIES(SIG_ENTRIES),
		.HISTORY_LEN(HISTORY_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.action     (action),
		.set_index  (set_index),
		.way_index  (way_index),
		.access_pc  (access_pc),
		.access_addr(access_addr),
		.was_hit    (was_hit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.victim_way (victim_way)
	);
endmodule

[tb/tb.sv]
// Self-checking testbench for the signature and stride aware RRIP replacement block.
`timescale 1ns / 1ps

module tb;
	import ssrr_pkg::*;

	localparam int SETS      = DEF_NUM_SETS;
	localparam int WAYS      = DEF_NUM_WAYS;
	localparam int SIGS      = DEF_SIG_ENTRIES;
	localparam int HLEN      = DEF_HISTORY_LEN;
	localparam int DRAIN     = 400;     // worst victim search plus margin
	localparam int STALL_MAX = 150000;  // covers the post-reset memory sweep

	typedef struct packed {
		logic                act;
		logic [SET_IN_W-1:0] set;
		logic [WAY_IN_W-1:0] way;
		logic [PC_W-1:0]     pc;
		logic [ADDR_W-1:0]   addr;
		logic                hit;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TOL_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [SET_IN_W-1:0] set_index = '0;
	logic [WAY_IN_W-1:0] way_index = '0;
	logic [PC_W-1:0] access_pc = '0;
	logic [ADDR_W-1:0] access_addr = '0;
	logic was_hit = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VICTIM_W-1:0] victim_way;

	always #4 clk = ~clk;

	signature_stride_rrip_replacement uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.set_index(set_index), .way_index(way_index), .access_pc(access_pc),
		.access_addr(access_addr), .was_hit(was_hit), .out_valid(out_valid),
		.out_ready(out_ready), .victim_way(victim_way)
	);

	// ---------------------------------------------------------------
	// Policy shadow state, one copy per set
	// ---------------------------------------------------------------
	logic [RRPV_W-1:0]  shd_rrpv  [SETS][WAYS];
	logic [PC_W-1:0]    shd_lpc   [SETS][WAYS];
	logic [ADDR_W-1:0]  shd_laddr [SETS][WAYS];
	logic [PC_W-1:0]    shd_spc   [SETS][SIGS];
	logic [REUSE_W-1:0] shd_reuse [SETS][SIGS];
	logic [STAMP_W-1:0] shd_stamp [SETS][SIGS];
	logic [STAMP_W-1:0] shd_tick  [SETS];
	logic [ADDR_W-1:0]  shd_hist  [SETS][HLEN];
	longint             shd_strd  [SETS][HLEN-1];
	int                 shd_ptr   [SETS];
	int                 shd_cnt   [SETS];
	logic [TOL_W-1:0]   shd_tol;

	logic [VICTIM_W-1:0] victims_due[$];  // expected victim ways, oldest first
	req_t                pending[$];      // requests waiting for the driver

	int errors = 0;
	int n_victims = 0, n_updates = 0, n_stride_runs = 0;
	int send_idle = 0, recv_idle = 0;
	int stall_cycles = 0;
	bit hold_done = 0;
	int hold_left = 0;

	function automatic longint abs_l(longint v);
		return v < 0 ? -v : v;
	endfunction

	// signature lookup; a missing PC takes the oldest-stamped entry
	function automatic int sig_lookup(int s, logic [PC_W-1:0] pc);
		int best;
		best = 0;
		for (int i = 0; i < SIGS; i++)
			if (shd_spc[s][i] == pc)
				return i;
		for (int i = 1; i < SIGS; i++)
			if (shd_stamp[s][i] < shd_stamp[s][best])
				best = i;
		shd_spc[s][best] = pc;
		shd_reuse[s][best] = REUSE_INIT;
		shd_tick[s] = shd_tick[s] + 1;
		shd_stamp[s][best] = shd_tick[s];
		return best;
	endfunction

	function automatic bit stride_steady(int s);
		if (shd_cnt[s] < HLEN)
			return 0;
		for (int i = 1; i < HLEN - 1; i++)
			if (abs_l(shd_strd[s][i] - shd_strd[s][0]) > longint'(shd_tol))
				return 0;
		return 1;
	endfunction

	function automatic logic [ADDR_W-1:0] newest_addr(int s);
		return shd_hist[s][(shd_ptr[s] + HLEN - 1) % HLEN];
	endfunction

	// Applies one accepted request; victim requests queue the expected way.
	function automatic void apply_request(req_t r);
		int s, e, p;
		int unsigned top, pick, minr, reuse;
		bit steady, match;
		longint st;
		s = int'(r.set) % SETS;
		if (r.act == ACT_VICTIM) begin
			top = 0; pick = 0; minr = 8;
			steady = stride_steady(s);
			if (steady)
				n_stride_runs++;
			for (int w = 0; w < WAYS; w++)
				if (shd_rrpv[s][w] > top)
					top = shd_rrpv[s][w];
			for (int w = 0; w < WAYS; w++) begin
				if (shd_rrpv[s][w] != top)
					continue;
				reuse = shd_reuse[s][sig_lookup(s, shd_lpc[s][w])];
				match = 0;
				if (steady) begin
					st = longint'({16'd0, shd_laddr[s][w]}) - longint'({16'd0, newest_addr(s)});
					match = abs_l(st - shd_strd[s][0]) <= longint'(shd_tol);
				end
				if (reuse < minr || (reuse == minr && !match)) begin
					minr = reuse;
					pick = w;
				end
			end
			victims_due.push_back(VICTIM_W'(pick));
			n_victims++;
		end else begin
			n_updates++;
			p = shd_ptr[s];
			st = longint'({16'd0, r.addr}) - longint'({16'd0, newest_addr(s)});
			if (shd_cnt[s] < HLEN)
				shd_cnt[s]++;
			if (p > 0)
				shd_strd[s][p-1] = st;
			shd_hist[s][p] = r.addr;
			shd_ptr[s] = (p + 1) % HLEN;
			e = sig_lookup(s, r.pc);
			shd_tick[s] = shd_tick[s] + 1;
			shd_stamp[s][e] = shd_tick[s];
			reuse = shd_reuse[s][e];
			if (r.hit)
				reuse = reuse < REUSE_MAX ? reuse + 1 : REUSE_MAX;
			else
				reuse = reuse > 1 ? reuse - 1 : 1;
			shd_reuse[s][e] = REUSE_W'(reuse);
			steady = stride_steady(s);
			shd_lpc[s][r.way] = r.pc;
			shd_laddr[s][r.way] = r.addr;
			if (r.hit || reuse >= REUSE_HOT || steady)
				shd_rrpv[s][r.way] = RRPV_HIT;
			else if (reuse >= REUSE_WARM)
				shd_rrpv[s][r.way] = RRPV_NEAR;
			else
				shd_rrpv[s][r.way] = RRPV_INSERT;
		end
	endfunction

	task automatic report(string what, logic [VICTIM_W-1:0] got, logic [VICTIM_W-1:0] want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// Driver: request channel. Valid holds until the transaction is taken.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		req_t r;
		bit   take;
		if (in_valid && in_ready)
			apply_request('{action, set_index, way_index, access_pc, access_addr, was_hit});
		if (!in_valid || in_ready) begin
			take = arst_n && pending.size() > 0 && $urandom_range(99) >= send_idle;
			if (take) begin
				r = pending.pop_front();
				action <= r.act;
				set_index <= r.set;
				way_index <= r.way;
				access_pc <= r.pc;
				access_addr <= r.addr;
				was_hit <= r.hit;
			end
			in_valid <= take;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: result channel, plus one long back-pressure stretch
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (victims_due.size() == 0) begin
				report("victim_way with none due", victim_way, '0);
			end else begin
				logic [VICTIM_W-1:0] want;
				want = victims_due.pop_front();
				if (victim_way !== want)
					report("victim_way", victim_way, want);
			end
		end
		if (!hold_done && n_victims == 40 && send_idle == 17) begin
			hold_done <= 1;
			hold_left <= 600;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	// Watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("signature_stride_rrip_replacement regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic logic [47:0] rnd48();
		return {$urandom, $urandom};
	endfunction

	task automatic push_upd(int s, int w, logic [47:0] pc, logic [47:0] a, bit h);
		pending.push_back('{ACT_UPDATE, SET_IN_W'(s), WAY_IN_W'(w), pc, a, h});
	endtask

	task automatic push_vic(int s);
		// update-only fields carry noise on victim requests
		pending.push_back('{ACT_VICTIM, SET_IN_W'(s), WAY_IN_W'($urandom_range(15)),
			rnd48(), rnd48(), 1'($urandom)});
	endtask

	task automatic set_tolerance(logic [TOL_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		shd_tol = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender pause: nothing offered until every victim has come back
	task automatic drain();
		while (pending.size() > 0 || in_valid || victims_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Mostly strided access streams on a few hot sets, with victim queries between
	task automatic random_phase(int n);
		int hot[4];
		longint unsigned base[4];
		int stride[4];
		logic [47:0] pcs[4];
		int k, h;
		for (int i = 0; i < 4; i++) begin
			hot[i] = $urandom_range(SETS - 1);
			base[i] = rnd48();
			stride[i] = $urandom_range(1, 4) * 64;
			pcs[i] = rnd48();
		end
		k = 0;
		while (k < n) begin
			h = $urandom_range(3);
			if ($urandom_range(9) < 2) begin
				// noise: anything the fields allow
				if ($urandom & 1)
					push_upd($urandom_range(SETS - 1), $urandom_range(15), rnd48(), rnd48(),
						$urandom & 1);
				else
					push_vic($urandom_range(SETS - 1));
				k++;
			end else begin
				for (int j = 0; j < $urandom_range(2, 5); j++) begin
					base[h] = base[h] + stride[h] + $urandom_range(0, 1) * $urandom_range(0, 80);
					push_upd(hot[h], $urandom_range(15),
						($urandom_range(3) == 0) ? pcs[$urandom_range(3)] ^ (1 << $urandom_range(3)) : pcs[h],
						base[h][47:0], $urandom_range(2) != 0);
					k++;
				end
				push_vic(hot[h]);
				k++;
			end
		end
	endtask

	initial begin
		for (int s = 0; s < SETS; s++) begin
			shd_tick[s] = 0; shd_ptr[s] = 0; shd_cnt[s] = 0;
			for (int w = 0; w < WAYS; w++) begin
				shd_rrpv[s][w] = RRPV_MAX; shd_lpc[s][w] = '0; shd_laddr[s][w] = '0;
			end
			for (int i = 0; i < SIGS; i++) begin
				shd_spc[s][i] = '0; shd_reuse[s][i] = REUSE_INIT; shd_stamp[s][i] = '0;
			end
			for (int i = 0; i < HLEN; i++)
				shd_hist[s][i] = '0;
			for (int i = 0; i < HLEN - 1; i++)
				shd_strd[s][i] = 0;
		end
		shd_tol = TOL_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_tolerance(TOL_RESET);

		// phase 1: directed corners, then random; slow-ish sender, lazy receiver
		send_idle = 17; recv_idle = 58;
		push_vic(0);                                        // fresh set: all ways tie
		push_vic(SETS - 1);
		push_upd(SETS - 1, 15, '1, '1, 1);                  // field maxima, hit
		push_upd(SETS - 1, 0, '0, '0, 0);                   // field minima, miss
		push_vic(SETS - 1);
		for (int i = 0; i < 3; i++)
			push_upd(5, 3, 48'h1234, 48'h1000, 0);          // reuse stays floored
		for (int i = 0; i < 8; i++)
			push_upd(5, 7, 48'h5678, 48'h1000, 1);          // reuse saturates
		push_vic(5);
		for (int i = 0; i < 5; i++)
			push_upd(9, i + 10, 48'hABC0 + i, 48'h40000 + 64 * i, 0);  // steady stride
		push_vic(9);
		push_upd(9, 1, 48'hABC0, 48'h0, 0);                // stride breaks
		push_vic(9);
		random_phase(230);
		drain();

		// phase 2: zero tolerance, rates reversed: slow sender, eager receiver
		set_tolerance('0);
		send_idle = 58; recv_idle = 17;
		random_phase(250);
		drain();

		// phase 3: widest tolerance, no idling at all
		set_tolerance('1);
		send_idle = 0; recv_idle = 0;
		random_phase(130);
		drain();
		set_tolerance(TOL_W'($urandom_range(1, 4094)));
		random_phase(120);
		drain();

		$display("covered %0d updates and %0d victim queries, %0d under a steady stride,",
			n_updates, n_victims, n_stride_runs);
		$display("tolerance at 64, 0, 4095 and a random value; %0d mismatches", errors);
		if (errors == 0)
			$display("signature_stride_rrip_replacement regression: pass");
		else
			$display("signature_stride_rrip_replacement regression: fail");
		$finish;
	end

endmodule
